>>> rtl/bf_run_length_bracket_lexer_top_assert.svh
// Assertion macros for the bracket lexer.
// Define NO_ASSERTIONS to compile them out.
`ifndef BF_RUN_LENGTH_BRACKET_LEXER_TOP_ASSERT_SVH
`define BF_RUN_LENGTH_BRACKET_LEXER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Implication checked on every clock edge outside reset.
`define BFL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define BFL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFL_ASSERT_IMP(lbl, ante, cons, msg)
`define BFL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/bfl_pkg.sv
// ----------------------------------------------------------------------------
// bfl_pkg
// Types, constants and helpers shared by the bracket lexer modules.
// ----------------------------------------------------------------------------
package bfl_pkg;

    localparam int unsigned STACK_DEPTH = 256;
    localparam int unsigned MAX_TOKENS  = 65536;
    localparam int unsigned MAX_RUN     = 65535;
    localparam int unsigned MAX_BYTES   = 1048576;

    localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SA_W   = $clog2(STACK_DEPTH);
    localparam int unsigned TOK_W  = $clog2(MAX_TOKENS + 1);
    localparam int unsigned ENT_W  = $clog2(MAX_TOKENS);
    localparam int unsigned CNT_W  = $clog2(MAX_RUN + 1);
    localparam int unsigned BYTE_W = $clog2(MAX_BYTES + 1);

    // fixed widths of the result fields
    localparam int unsigned IDX_W  = 17;
    localparam int unsigned OPND_W = 17;
    localparam int unsigned POS_W  = 21;

    localparam int unsigned MAX_RES = 4;
    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QA_W    = $clog2(QDEPTH);
    localparam int unsigned QC_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef enum logic [1:0] {
        KIND_TOKEN = 2'd0,
        KIND_PATCH = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_UNBALANCED = 2'd0,
        ERR_STACK_FULL = 2'd1,
        ERR_STORE_FULL = 2'd2
    } err_code_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        op;
        logic [IDX_W-1:0]  index;
        logic [OPND_W-1:0] operand;
        err_code_t         code;
        logic [POS_W-1:0]  pos;
    } result_t;

    // all results caused by one input beat
    typedef struct packed {
        logic [2:0]            count;
        result_t [MAX_RES-1:0] res;
    } bundle_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // working copy of the lexer state while one byte is evaluated
    typedef struct packed {
        logic [7:0]            pend_op;
        logic [CNT_W-1:0]      pend_cnt;
        logic [TOK_W-1:0]      tok;
        logic                  err;
        logic                  ok;
        logic [2:0]            n;
        result_t [MAX_RES-1:0] res;
    } lex_work_t;

    function automatic result_t make_res(kind_t kind, logic [7:0] op,
                                         logic [IDX_W-1:0] index,
                                         logic [OPND_W-1:0] operand,
                                         err_code_t code, logic [POS_W-1:0] pos);
        result_t r;
        r.kind    = kind;
        r.op      = op;
        r.index   = index;
        r.operand = operand;
        r.code    = code;
        r.pos     = pos;
        return r;
    endfunction

endpackage

>>> rtl/bfl_text_if.sv
// ----------------------------------------------------------------------------
// bfl_text_if
// Input channel: one source byte per beat.
// ----------------------------------------------------------------------------
interface bfl_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       end_of_text;

    modport source (output valid, output source_byte, output end_of_text, input ready);
    modport sink   (input valid, input source_byte, input end_of_text, output ready);
endinterface

>>> rtl/bfl_result_if.sv
// ----------------------------------------------------------------------------
// bfl_result_if
// Output channel: one lexer result per beat.
// ----------------------------------------------------------------------------
interface bfl_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  token_op;
    logic [16:0] token_index;
    logic [16:0] operand;
    logic [1:0]  error_code;
    logic [20:0] error_position;
    logic        last_of_run;

    modport source (output valid, output result_kind, output token_op, output token_index,
                    output operand, output error_code, output error_position,
                    output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input token_op, input token_index,
                    input operand, input error_code, input error_position,
                    input last_of_run, output ready);
endinterface

>>> rtl/bf_run_length_bracket_lexer_top.sv
// ----------------------------------------------------------------------------
// bf_run_length_bracket_lexer_top
// Run-length lexer for the eight-command tape language with bracket matching.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  text     in   source_byte, end_of_text
//  result   out  result_kind, token_op, token_index, operand, error_code,
//                error_position, last_of_run
//
// One byte is taken per cycle while the result queue has room; a ']' that leaves
// brackets open stalls input while the new stack top is read back from the stack
// memory. A byte's results (up to four) go out one per beat, and a four-bundle
// queue lets input run ahead of output.
// Reset needs no clearing pass; stack entries are only read after being written.
// ----------------------------------------------------------------------------
module bf_run_length_bracket_lexer_top (
    input  logic          clk,
    input  logic          rst_n,
    bfl_text_if.sink      text,
    bfl_result_if.source  result
);
    import bfl_pkg::*;

    q_status_t q_stat;
    bundle_t   wr_bundle;
    bundle_t   head;
    logic      push;
    logic      pop;

    bfl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_stat (q_stat),
        .push   (push),
        .bundle (wr_bundle)
    );

    bfl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_bundle (wr_bundle),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    bfl_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .result (result)
    );

endmodule

>>> rtl/bfl_front.sv
// ----------------------------------------------------------------------------
// bfl_front
// Classifies source bytes, keeps run, token and bracket state, and builds the
// bundle of results for each byte.
// ----------------------------------------------------------------------------
`include "bf_run_length_bracket_lexer_top_assert.svh"

module bfl_front (
    input  logic                clk,
    input  logic                rst_n,
    bfl_text_if.sink            text,
    input  bfl_pkg::q_status_t  q_stat,
    output logic                push,
    output bfl_pkg::bundle_t    bundle
);
    import bfl_pkg::*;

    logic [7:0]        pend_op_reg;
    logic [CNT_W-1:0]  pend_cnt_reg;
    logic [TOK_W-1:0]  tok_reg;
    logic [BYTE_W-1:0] bytes_reg;
    logic [SP_W-1:0]   sp_reg;
    logic              err_reg;
    logic              refill_reg;
    logic              refill_next;
    logic [ENT_W-1:0]  top_reg;
    logic [ENT_W-1:0]  rdata_reg;
    logic [ENT_W-1:0]  stack_mem [STACK_DEPTH];

    logic              acc;
    logic [BYTE_W-1:0] bytes_inc;
    logic [POS_W-1:0]  pos;
    lex_work_t         w;
    logic              stk_push;
    logic              stk_pop;
    logic [ENT_W-1:0]  open_idx;
    logic [SP_W-1:0]   sp_new;
    logic [SA_W-1:0]   rd_addr;

    function automatic lex_work_t add_res(lex_work_t wi, result_t r);
        lex_work_t wo;
        wo = wi;
        wo.res[wi.n[1:0]] = r;
        wo.n = wi.n + 3'd1;
        return wo;
    endfunction

    function automatic lex_work_t emit_token(lex_work_t wi, logic [7:0] op,
                                             logic [OPND_W-1:0] opnd,
                                             logic [POS_W-1:0] p);
        lex_work_t wo;
        wo = wi;
        if (wi.tok >= TOK_W'(MAX_TOKENS))
        begin
            wo = add_res(wo, make_res(KIND_ERROR, CH_NONE, '0, '0, ERR_STORE_FULL, p));
            wo.err = 1'b1;
            wo.ok  = 1'b0;
        end
        else
        begin
            wo = add_res(wo, make_res(KIND_TOKEN, op, IDX_W'(wi.tok), opnd,
                                      ERR_UNBALANCED, '0));
            wo.tok = wi.tok + 1'b1;
            wo.ok  = 1'b1;
        end
        return wo;
    endfunction

    function automatic lex_work_t flush_run(lex_work_t wi, logic [POS_W-1:0] p);
        lex_work_t wo;
        wo = wi;
        wo.ok = 1'b1;
        if (wi.pend_op != CH_NONE)
            wo = emit_token(wo, wi.pend_op, OPND_W'(wi.pend_cnt), p);
        wo.pend_op  = CH_NONE;
        wo.pend_cnt = '0;
        return wo;
    endfunction

    assign acc        = text.valid && text.ready;
    assign text.ready = !q_stat.full && !refill_reg;

    assign bytes_inc = (bytes_reg < BYTE_W'(MAX_BYTES)) ? bytes_reg + 1'b1 : bytes_reg;
    assign pos       = POS_W'(bytes_inc);

    always_comb
    begin
        w          = '0;
        w.pend_op  = pend_op_reg;
        w.pend_cnt = pend_cnt_reg;
        w.tok      = tok_reg;
        w.err      = err_reg;
        w.ok       = 1'b1;
        stk_push   = 1'b0;
        stk_pop    = 1'b0;
        open_idx   = '0;
        if (!err_reg)
        begin
            case (text.source_byte)
                CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_DOT, CH_COMMA:
                begin
                    if (w.pend_op != text.source_byte)
                        w = flush_run(w, pos);
                    if (w.ok)
                    begin
                        w.pend_op  = text.source_byte;
                        w.pend_cnt = w.pend_cnt + 1'b1;
                        if (w.pend_cnt >= CNT_W'(MAX_RUN))
                            w = flush_run(w, pos);
                    end
                end
                CH_OPEN:
                begin
                    w = flush_run(w, pos);
                    if (w.ok)
                    begin
                        if (sp_reg >= SP_W'(STACK_DEPTH))
                        begin
                            w = add_res(w, make_res(KIND_ERROR, CH_NONE, '0, '0,
                                                    ERR_STACK_FULL, pos));
                            w.err = 1'b1;
                        end
                        else
                        begin
                            // index of the '[' token, after any flushed run
                            open_idx = w.tok[ENT_W-1:0];
                            w = emit_token(w, CH_OPEN, '0, pos);
                            stk_push = w.ok;
                        end
                    end
                end
                CH_CLOSE:
                begin
                    w = flush_run(w, pos);
                    if (w.ok)
                    begin
                        if (sp_reg == '0)
                        begin
                            w = add_res(w, make_res(KIND_ERROR, CH_NONE, '0, '0,
                                                    ERR_UNBALANCED, pos));
                            w.err = 1'b1;
                        end
                        else
                        begin
                            w = emit_token(w, CH_CLOSE, OPND_W'(top_reg) + 1'b1, pos);
                            if (w.ok)
                            begin
                                stk_pop = 1'b1;
                                w = add_res(w, make_res(KIND_PATCH, CH_OPEN, IDX_W'(top_reg),
                                                        OPND_W'(w.tok), ERR_UNBALANCED,
                                                        '0));
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (text.end_of_text)
        begin
            if (!w.err)
                w = flush_run(w, pos);
            w = add_res(w, make_res(KIND_DONE, CH_NONE, IDX_W'(w.tok), '0,
                                    ERR_UNBALANCED, '0));
        end
    end

    assign sp_new      = stk_push ? sp_reg + 1'b1 : (stk_pop ? sp_reg - 1'b1 : sp_reg);
    assign rd_addr     = SA_W'(sp_new - 1'b1);
    // after a pop that leaves brackets open, the new top is refilled from the registered stack memory read
    assign refill_next = acc && stk_pop && !text.end_of_text && (sp_new != '0);

    assign push         = acc && (w.n != 3'd0);
    assign bundle.count = w.n;
    assign bundle.res   = w.res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_op_reg  <= CH_NONE;
            pend_cnt_reg <= '0;
            tok_reg      <= '0;
            bytes_reg    <= '0;
            sp_reg       <= '0;
            err_reg      <= 1'b0;
            refill_reg   <= 1'b0;
        end
        else
        begin
            refill_reg <= refill_next;
            if (acc)
            begin
                if (text.end_of_text)
                begin
                    pend_op_reg  <= CH_NONE;
                    pend_cnt_reg <= '0;
                    tok_reg      <= '0;
                    bytes_reg    <= '0;
                    sp_reg       <= '0;
                    err_reg      <= 1'b0;
                end
                else
                begin
                    pend_op_reg  <= w.pend_op;
                    pend_cnt_reg <= w.pend_cnt;
                    tok_reg      <= w.tok;
                    bytes_reg    <= bytes_inc;
                    sp_reg       <= sp_new;
                    err_reg      <= w.err;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && stk_push)
            stack_mem[sp_reg[SA_W-1:0]] <= open_idx;
        rdata_reg <= stack_mem[rd_addr];
        if (acc && stk_push)
            top_reg <= open_idx;
        else if (refill_reg)
            top_reg <= rdata_reg;
    end

    `BFL_ASSERT_IMP(a_sp_bound, 1'b1, sp_reg <= SP_W'(STACK_DEPTH), "stack pointer past depth")
    `BFL_ASSERT_IMP(a_err_silent, acc && err_reg && !text.end_of_text, !push,
                    "result after error before end of text")
    `BFL_ASSERT_NXT(a_refill_src, acc && stk_push, !refill_reg, "refill after a push")

endmodule

>>> rtl/bfl_queue.sv
// ----------------------------------------------------------------------------
// bfl_queue
// Short FIFO of result bundles between the front and the back.
// ----------------------------------------------------------------------------
`include "bf_run_length_bracket_lexer_top_assert.svh"

module bfl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bfl_pkg::bundle_t    wr_bundle,
    input  logic                pop,
    output bfl_pkg::bundle_t    head,
    output bfl_pkg::q_status_t  q_stat
);
    import bfl_pkg::*;

    bundle_t          entries [QDEPTH];
    logic [QA_W-1:0]  wr_ptr_reg;
    logic [QA_W-1:0]  rd_ptr_reg;
    logic [QC_W-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == QC_W'(QDEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entries[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= wr_bundle;
    end

    `BFL_ASSERT_IMP(a_no_drop, push, !q_stat.full, "bundle pushed into full queue")

endmodule

>>> rtl/bfl_back.sv
// ----------------------------------------------------------------------------
// bfl_back
// Walks the head bundle one result per beat into the output register.
// ----------------------------------------------------------------------------
module bfl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  bfl_pkg::bundle_t    head,
    input  bfl_pkg::q_status_t  q_stat,
    output logic                pop,
    bfl_result_if.source        result
);
    import bfl_pkg::*;

    logic       out_valid_reg;
    result_t    out_res_reg;
    logic       out_last_reg;
    logic [1:0] slot_reg;
    logic       load;
    logic       slot_last;

    assign load      = (!out_valid_reg || result.ready) && !q_stat.empty;
    assign slot_last = ({1'b0, slot_reg} == head.count - 3'd1);
    assign pop       = load && slot_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                slot_reg      <= slot_last ? 2'd0 : slot_reg + 2'd1;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg  <= head.res[slot_reg];
            out_last_reg <= slot_last;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.result_kind    = out_res_reg.kind;
    assign result.token_op       = out_res_reg.op;
    assign result.token_index    = out_res_reg.index;
    assign result.operand        = out_res_reg.operand;
    assign result.error_code     = out_res_reg.code;
    assign result.error_position = out_res_reg.pos;
    assign result.last_of_run    = out_last_reg;

endmodule
